// ===== hw/rtl/pic_pkg.sv =====
// Package with the shared types, codes and constants of the interrupt controller.
package pic_pkg;

    localparam int NUM_BANKS = 4;
    localparam int NUM_LINES = 128;
    localparam int BANK_W = 2;
    localparam int LINE_W = 7;
    localparam int PRIO_W = 6;

    localparam logic [1:0] CMD_LINE  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [3:0] SEL_ITR       = 4'd0;
    localparam logic [3:0] SEL_MIR       = 4'd1;
    localparam logic [3:0] SEL_MIR_CLEAR = 4'd2;
    localparam logic [3:0] SEL_MIR_SET   = 4'd3;
    localparam logic [3:0] SEL_ISR       = 4'd4;
    localparam logic [3:0] SEL_ISR_CLEAR = 4'd5;
    localparam logic [3:0] SEL_PENDING   = 4'd6;
    localparam logic [3:0] SEL_ILR       = 4'd7;
    localparam logic [3:0] SEL_SIR       = 4'd8;
    localparam logic [3:0] SEL_CONTROL   = 4'd9;
    localparam logic [3:0] SEL_SYSCONFIG = 4'd10;
    localparam logic [3:0] SEL_THRESHOLD = 4'd11;
    localparam logic [3:0] SEL_SYSSTATUS = 4'd12;
    localparam logic [3:0] SEL_REVISION  = 4'd13;
    localparam logic [3:0] SEL_UNUSED    = 4'd15;

    localparam logic [31:0] REVISION_VALUE = 32'h5000_0001;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  reg_sel;
        logic [1:0]  bank;
        logic [6:0]  line;
        logic        level;
        logic [31:0] wdata;
    } cmd_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq_out;
        logic        active_valid;
        logic [6:0]  active_irq;
    } rsp_t;

endpackage

// ===== hw/rtl/pic_if.sv =====
// Valid/ready channel interface carrying one beat of a given payload type.
interface pic_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pic_ram.sv =====
// Generic single-port RAM with registered read.
module pic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/pic_front.sv =====
// Front end: accepts command beats into a two-entry queue.
module pic_front (
    input  logic          clk,
    input  logic          rst_n,
    pic_if.sink           cmd_in,
    output logic          q_valid,
    output pic_pkg::cmd_t q_data,
    input  logic          q_pop
);
    pic_pkg::cmd_t ent_reg [2];
    logic [1:0]    cnt_reg;
    logic          rd_reg;
    logic          wr_reg;
    logic          push;

    assign cmd_in.ready = (cnt_reg != 2'd2);
    assign push = cmd_in.valid && cmd_in.ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = ent_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= cmd_in.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (q_pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    ovf_chk: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    pop_chk: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    full_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !cmd_in.ready) else $error("push into full queue");
endmodule

// ===== hw/rtl/pic_back.sv =====
// Back end: register file, priority scan over the lines and result register.
module pic_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  pic_pkg::cmd_t q_data,
    output logic          q_pop,
    pic_if.source         rsp_out
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_SCRD = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_CLR  = 3'd6;

    logic [2:0]  state_reg;
    pic_pkg::cmd_t c_reg;
    logic [31:0] lvl_reg [pic_pkg::NUM_BANKS];
    logic [31:0] soft_reg [pic_pkg::NUM_BANKS];
    logic [31:0] mask_reg [pic_pkg::NUM_BANKS];
    logic [pic_pkg::NUM_LINES-1:0] ilr_ok_reg;
    logic [31:0] sysc_reg;
    logic [31:0] thr_reg;
    logic [pic_pkg::LINE_W-1:0] idx_reg;
    logic        found_reg;
    logic [pic_pkg::LINE_W-1:0] best_reg;
    logic [pic_pkg::PRIO_W-1:0] bprio_reg;
    logic        act_v_reg;
    logic [pic_pkg::LINE_W-1:0] act_n_reg;
    logic [pic_pkg::PRIO_W-1:0] act_p_reg;
    logic [31:0] rdata_hold_reg;
    logic        ovalid_reg;
    pic_pkg::rsp_t out_reg;

    logic        ram_we;
    logic [pic_pkg::LINE_W-1:0] ram_addr;
    logic [31:0] ram_rd;
    logic [31:0] ilr_val;
    logic [31:0] rdata_sel;
    logic [31:0] pend_w;
    logic        pbit;
    logic [pic_pkg::PRIO_W-1:0] pr;
    logic        is_w;
    logic        clr_ok;

    pic_ram #(.WIDTH(32), .DEPTH(pic_pkg::NUM_LINES)) u_ilr (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(c_reg.wdata), .rdata(ram_rd)
    );

    assign is_w = (c_reg.cmd == pic_pkg::CMD_WRITE);
    assign ram_we = (state_reg == ST_EXEC) && is_w && (c_reg.reg_sel == pic_pkg::SEL_ILR);
    assign ram_addr = (state_reg == ST_SCAN || state_reg == ST_SCRD) ? idx_reg : c_reg.line;
    assign ilr_val = ilr_ok_reg[ram_addr] ? ram_rd : 32'd0;
    assign pend_w = (lvl_reg[idx_reg[6:5]] | soft_reg[idx_reg[6:5]]) & ~mask_reg[idx_reg[6:5]];
    assign pbit = pend_w[idx_reg[4:0]];
    assign pr = ilr_val[7:2];
    assign clr_ok = is_w && (c_reg.reg_sel == pic_pkg::SEL_SYSCONFIG) && c_reg.wdata[1];
    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign rsp_out.valid = ovalid_reg;
    assign rsp_out.data = out_reg;

    always_comb
    begin
        rdata_sel = 32'd0;
        if (c_reg.cmd == pic_pkg::CMD_READ)
        begin
            case (c_reg.reg_sel)
                pic_pkg::SEL_ITR: rdata_sel = lvl_reg[c_reg.bank];
                pic_pkg::SEL_MIR: rdata_sel = mask_reg[c_reg.bank];
                pic_pkg::SEL_ISR: rdata_sel = soft_reg[c_reg.bank];
                pic_pkg::SEL_PENDING: rdata_sel = (lvl_reg[c_reg.bank]
                    | soft_reg[c_reg.bank]) & ~mask_reg[c_reg.bank];
                pic_pkg::SEL_ILR: rdata_sel = ilr_val;
                pic_pkg::SEL_SIR: rdata_sel = act_v_reg
                    ? {19'd0, act_p_reg, act_n_reg} : 32'd0;
                pic_pkg::SEL_SYSCONFIG: rdata_sel = sysc_reg;
                pic_pkg::SEL_THRESHOLD: rdata_sel = thr_reg;
                pic_pkg::SEL_SYSSTATUS: rdata_sel = 32'd1;
                pic_pkg::SEL_REVISION: rdata_sel = pic_pkg::REVISION_VALUE;
                default: rdata_sel = 32'd0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            c_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int b = 0; b < pic_pkg::NUM_BANKS; b++)
            begin
                lvl_reg[b] <= 32'd0;
                soft_reg[b] <= 32'd0;
                mask_reg[b] <= pic_pkg::ALL_ONES;
            end
            ilr_ok_reg <= '0;
            sysc_reg <= 32'd0;
            thr_reg <= 32'd0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            best_reg <= '0;
            bprio_reg <= '0;
            act_v_reg <= 1'b0;
            act_n_reg <= '0;
            act_p_reg <= '0;
            rdata_hold_reg <= 32'd0;
            ovalid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            if (rsp_out.valid && rsp_out.ready && state_reg != ST_OUT)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    rdata_hold_reg <= rdata_sel;
                    state_reg <= ST_SCAN;
                    idx_reg <= '0;
                    found_reg <= 1'b0;
                    if (c_reg.cmd == pic_pkg::CMD_LINE)
                    begin
                        lvl_reg[c_reg.line[6:5]][c_reg.line[4:0]] <= c_reg.level;
                    end
                    else if (is_w)
                    begin
                        case (c_reg.reg_sel)
                            pic_pkg::SEL_MIR: mask_reg[c_reg.bank] <= c_reg.wdata;
                            pic_pkg::SEL_MIR_CLEAR: mask_reg[c_reg.bank] <=
                                mask_reg[c_reg.bank] & ~c_reg.wdata;
                            pic_pkg::SEL_MIR_SET: mask_reg[c_reg.bank] <=
                                mask_reg[c_reg.bank] | c_reg.wdata;
                            pic_pkg::SEL_ISR: soft_reg[c_reg.bank] <=
                                soft_reg[c_reg.bank] | c_reg.wdata;
                            pic_pkg::SEL_ISR_CLEAR: soft_reg[c_reg.bank] <=
                                soft_reg[c_reg.bank] & ~c_reg.wdata;
                            pic_pkg::SEL_ILR: ilr_ok_reg[c_reg.line] <= 1'b1;
                            pic_pkg::SEL_CONTROL:
                            begin
                                if (c_reg.wdata[0] && act_v_reg)
                                begin
                                    lvl_reg[act_n_reg[6:5]][act_n_reg[4:0]] <= 1'b0;
                                    soft_reg[act_n_reg[6:5]][act_n_reg[4:0]] <= 1'b0;
                                end
                            end
                            pic_pkg::SEL_SYSCONFIG:
                            begin
                                sysc_reg <= c_reg.wdata;
                                if (clr_ok)
                                begin
                                    for (int b = 0; b < pic_pkg::NUM_BANKS; b++)
                                    begin
                                        lvl_reg[b] <= 32'd0;
                                        soft_reg[b] <= 32'd0;
                                        mask_reg[b] <= pic_pkg::ALL_ONES;
                                    end
                                    ilr_ok_reg <= '0;
                                    thr_reg <= 32'd0;
                                end
                            end
                            pic_pkg::SEL_THRESHOLD: thr_reg <= c_reg.wdata;
                            default: ;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    state_reg <= ST_SCRD;
                end
                ST_SCRD:
                begin
                    if (pbit && (!found_reg || pr < bprio_reg))
                    begin
                        found_reg <= 1'b1;
                        best_reg <= idx_reg;
                        bprio_reg <= pr;
                    end
                    if (idx_reg == pic_pkg::LINE_W'(pic_pkg::NUM_LINES - 1))
                    begin
                        state_reg <= ST_CLR;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_CLR:
                begin
                    act_v_reg <= found_reg;
                    act_n_reg <= found_reg ? best_reg : '0;
                    act_p_reg <= bprio_reg;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!ovalid_reg || rsp_out.ready)
                    begin
                        out_reg.rdata <= rdata_hold_reg;
                        out_reg.irq_out <= act_v_reg;
                        out_reg.active_valid <= act_v_reg;
                        out_reg.active_irq <= act_n_reg;
                        ovalid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    st_chk: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == ST_RD) else $error("pop without start");
    act_chk: assert property (@(posedge clk) disable iff (!rst_n)
        !act_v_reg |-> act_n_reg == '0) else $error("active number without valid");
    out_chk: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> out_reg.irq_out == out_reg.active_valid)
        else $error("irq and valid differ");
endmodule

// ===== hw/rtl/priority_interrupt_controller.sv =====
// Top level of the 128-line priority interrupt controller.
// One channel takes command beats: a line level change, a register read or
// a register write. Each command beat gives exactly one result beat with read
// data (zero unless a read), the pending flag and the active line number as
// they stand after the command.
// Commands wait in a two-entry queue in front of the execution unit, so the
// sender can keep going while a command is worked on.
// The active line is found by scanning the level words one line at a time
// through the single port of the level word RAM.
// The unit takes no new command from the queue until it is through with the last one.
// Reset leaves all lines masked, nothing pending and the level words reading
// zero; a SYSCONFIG write with bit 1 set does the same.
// When the result receiver stalls, the result beat holds in the output
// register and the unit waits; the queue then fills and ready drops.
module priority_interrupt_controller (
    input logic clk,
    input logic rst_n,
    pic_if.sink   cmd_in,
    pic_if.source rsp_out
);
    logic          q_valid;
    logic          q_pop;
    pic_pkg::cmd_t q_data;

    pic_front u_front (
        .clk(clk), .rst_n(rst_n), .cmd_in(cmd_in),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
    );

    pic_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
        .q_pop(q_pop), .rsp_out(rsp_out)
    );
endmodule
